// File: design/line_position_error_tracker_macros.svh
// ----------------------------------------------------------------------------
// Line position error tracker assertion macros
// Shared property templates for the concurrent checks in the design.
// ----------------------------------------------------------------------------
`ifndef LINE_POSITION_ERROR_TRACKER_MACROS_SVH
`define LINE_POSITION_ERROR_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPET_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpet check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpet check failed");

`endif

// File: design/lpet_pkg.sv
// ----------------------------------------------------------------------------
// Line position error tracker package
// Shared constants, register indexes and types.
// ----------------------------------------------------------------------------
package lpet_pkg;

  // Default sizes of the converter samples and of the error fraction.
  localparam int ADC_BITS_DEF  = 12;
  localparam int FRAC_BITS_DEF = 8;

  // Register widths.
  localparam int THR_W      = 12;
  localparam int DB_W       = 10;
  localparam int HOLD_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 3'd4;

  // Register reset values.
  localparam logic [THR_W-1:0]  THR_RST  = 12'd2048;
  localparam logic [DB_W-1:0]   DB_RST   = 10'd26;
  localparam logic [HOLD_W-1:0] HOLD_RST = 8'd5;

  // Peak decay is 4/5: numerator is a shift by DECAY_SHIFT, then a division.
  localparam int DECAY_SHIFT = 2;
  localparam int DECAY_DEN   = 5;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: design/lpet_div.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// Produces one quotient bit per cycle from a preloaded partial remainder.
// ----------------------------------------------------------------------------
module lpet_div import lpet_pkg::*; #(
  parameter int ADC_BITS  = ADC_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic [$clog2(FRAC_BITS+DECAY_SHIFT+3)-1:0] steps_i,
  input  logic [ADC_BITS+1:0]                     rem_i,
  input  logic [FRAC_BITS+DECAY_SHIFT+1:0]        dvd_i,
  input  logic [ADC_BITS+1:0]                     den_i,
  output logic [FRAC_BITS+1:0]                    quo_o,
  output div_stat_t                               stat_o
);

  localparam int TW  = ADC_BITS + 2;
  localparam int DVW = FRAC_BITS + DECAY_SHIFT + 2;
  localparam int QW  = FRAC_BITS + 2;
  localparam int CW  = $clog2(FRAC_BITS + DECAY_SHIFT + 3);

  logic [TW-1:0]  rem_q, rem_d;
  logic [TW-1:0]  den_q, den_d;
  logic [DVW-1:0] dvd_q, dvd_d;
  logic [QW-1:0]  quo_q, quo_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;

  logic [TW:0]    rem_sh;
  logic [TW:0]    rem_sub;
  logic           ge;

  // One restoring step: bring in the next dividend bit, try the subtraction.
  assign rem_sh  = {rem_q, dvd_q[DVW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign ge      = rem_sh >= {1'b0, den_q};

  // Sequencing of the steps.
  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = rem_i;
      den_d  = den_i;
      dvd_d  = dvd_i;
      quo_d  = '0;
      cnt_d  = steps_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[TW-1:0] : rem_sh[TW-1:0];
      dvd_d = {dvd_q[DVW-2:0], 1'b0};
      quo_d = {quo_q[QW-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
  end

  assign quo_o       = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// File: design/line_position_error_tracker.sv
// ----------------------------------------------------------------------------
// Line position error tracker
// Turns left, center and right reflectance samples into a steering error.
// ----------------------------------------------------------------------------
// One item is a set of three samples; each yields one result on the output
// stream. The error 2*(right-left)/total is formed by a shared restoring
// divider that produces one quotient bit per cycle, and the same divider does
// the 4/5 peak decay. With the line in sight an item passes through the load,
// divide, post and emit states, plus the decay state when the error is
// centered and the peak decays; an item with no sensor on the line goes from
// load straight to emit. A new item is accepted only in the idle state, which
// the sequencer enters as it places the previous result in the output
// register, so items do not overlap; a stalled output holds it off.
`include "line_position_error_tracker_macros.svh"

module line_position_error_tracker import lpet_pkg::*; #(
  parameter int ADC_BITS  = ADC_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // Configuration write port.
  input  logic                                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                     cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]                    cfg_wdata_i,
  // Sample stream.
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // left_sample, center_sample, right_sample (ADC_BITS each), zero fill.
  input  logic [((3*ADC_BITS+7)/8)*8-1:0]          s_axis_tdata,
  // Error stream.
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // line_error (FRAC_BITS+3, two's complement), zero fill.
  output logic [((FRAC_BITS+3+7)/8)*8-1:0]         m_axis_tdata,
  // lost_flag.
  output logic                                     m_axis_tuser
);

  localparam int TW   = ADC_BITS + 2;
  localparam int EW   = FRAC_BITS + 3;
  localparam int QW   = FRAC_BITS + 2;
  localparam int DVW  = FRAC_BITS + DECAY_SHIFT + 2;
  localparam int CW   = $clog2(FRAC_BITS + DECAY_SHIFT + 3);
  localparam int OTW  = ((EW + 7) / 8) * 8;
  localparam int MW   = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;
  localparam int DBCW = (QW > DB_W) ? QW : DB_W;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_POST  = 3'd3;
  localparam logic [2:0] ST_DECAY = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]          state_q, state_d;

  logic [THR_W-1:0]    lthr_q, lthr_d;
  logic [THR_W-1:0]    cthr_q, cthr_d;
  logic [THR_W-1:0]    rthr_q, rthr_d;
  logic [DB_W-1:0]     db_q, db_d;
  logic [HOLD_W-1:0]   hold_smp_q, hold_smp_d;

  logic signed [EW-1:0] peak_q, peak_d;
  logic signed [EW-1:0] last_err_q, last_err_d;
  logic [HOLD_W-1:0]   hold_cnt_q, hold_cnt_d;
  logic                lost_q, lost_d;

  logic [ADC_BITS-1:0] lsmp_q, lsmp_d;
  logic [ADC_BITS-1:0] csmp_q, csmp_d;
  logic [ADC_BITS-1:0] rsmp_q, rsmp_d;
  logic                neg_q, neg_d;
  logic signed [EW-1:0] err_q, err_d;

  logic                mvalid_q, mvalid_d;
  logic [OTW-1:0]      mdata_q, mdata_d;
  logic                muser_q, muser_d;

  logic                in_acc;
  logic                out_acc;

  // Thresholds reduced to the converter width.
  logic [MW-1:0]       lthr_ext, cthr_ext, rthr_ext;
  logic [ADC_BITS-1:0] lthr, cthr, rthr;
  logic [ADC_BITS-1:0] lon, con, ron;
  logic [TW-1:0]       total;
  logic [ADC_BITS-1:0] diff_mag;
  logic                diff_neg;

  // Divider interface.
  logic                div_start;
  logic [CW-1:0]       div_steps;
  logic [TW-1:0]       div_rem;
  logic [DVW-1:0]      div_dvd;
  logic [TW-1:0]       div_den;
  logic [QW-1:0]       div_quo;
  div_stat_t           div_stat;

  // Post-division error and peak logic.
  logic signed [EW-1:0] quo_s;
  logic signed [EW-1:0] err_v;
  logic                in_dead;
  logic signed [EW-1:0] peak_abs;
  logic [QW-1:0]       peak_mag;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = mvalid_q && m_axis_tready;

  assign lthr_ext = MW'(lthr_q);
  assign cthr_ext = MW'(cthr_q);
  assign rthr_ext = MW'(rthr_q);
  assign lthr     = lthr_ext[ADC_BITS-1:0];
  assign cthr     = cthr_ext[ADC_BITS-1:0];
  assign rthr     = rthr_ext[ADC_BITS-1:0];

  // On-line amounts, their total and the signed left-right difference.
  assign lon      = (lsmp_q < lthr) ? (lthr - lsmp_q) : '0;
  assign con      = (csmp_q < cthr) ? (cthr - csmp_q) : '0;
  assign ron      = (rsmp_q < rthr) ? (rthr - rsmp_q) : '0;
  assign total    = TW'(lon) + TW'(con) + TW'(ron);
  assign diff_neg = lon > ron;
  assign diff_mag = diff_neg ? (lon - ron) : (ron - lon);

  // Signed error from the quotient, then the dead zone.
  assign quo_s   = $signed({1'b0, div_quo});
  assign in_dead = DBCW'(div_quo) < DBCW'(db_q);
  assign err_v   = in_dead ? '0 : (neg_q ? -quo_s : quo_s);

  // Peak magnitude for the decay.
  assign peak_abs = peak_q[EW-1] ? -peak_q : peak_q;
  assign peak_mag = peak_abs[QW-1:0];

  // Sequencer, state update and configuration writes.
  always_comb begin
    state_d    = state_q;
    lthr_d     = lthr_q;
    cthr_d     = cthr_q;
    rthr_d     = rthr_q;
    db_d       = db_q;
    hold_smp_d = hold_smp_q;
    peak_d     = peak_q;
    last_err_d = last_err_q;
    hold_cnt_d = hold_cnt_q;
    lost_d     = lost_q;
    lsmp_d     = lsmp_q;
    csmp_d     = csmp_q;
    rsmp_d     = rsmp_q;
    neg_d      = neg_q;
    err_d      = err_q;
    mvalid_d   = out_acc ? 1'b0 : mvalid_q;
    mdata_d    = mdata_q;
    muser_d    = muser_q;
    div_start  = 1'b0;
    div_steps  = CW'(FRAC_BITS + 2);
    div_rem    = TW'(diff_mag >> 1);
    div_dvd    = {diff_mag[0], {(DVW-1){1'b0}}};
    div_den    = total;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEFT_THR:   lthr_d     = cfg_wdata_i[THR_W-1:0];
        REG_CENTER_THR: cthr_d     = cfg_wdata_i[THR_W-1:0];
        REG_RIGHT_THR:  rthr_d     = cfg_wdata_i[THR_W-1:0];
        REG_DEAD_BAND:  db_d       = cfg_wdata_i[DB_W-1:0];
        REG_HOLD:       hold_smp_d = cfg_wdata_i[HOLD_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          lsmp_d  = s_axis_tdata[ADC_BITS-1:0];
          csmp_d  = s_axis_tdata[2*ADC_BITS-1:ADC_BITS];
          rsmp_d  = s_axis_tdata[3*ADC_BITS-1:2*ADC_BITS];
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (total == '0) begin
          // No sensor on the line: hold the last error, then search.
          if (hold_cnt_q != '0) begin
            hold_cnt_d = hold_cnt_q - HOLD_W'(1);
            lost_d     = 1'b0;
            err_d      = last_err_q;
          end else begin
            lost_d     = 1'b1;
            err_d      = peak_q;
            last_err_d = peak_q;
          end
          state_d = ST_EMIT;
        end else begin
          div_start = 1'b1;
          neg_d     = diff_neg;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_POST;
        end
      end
      ST_POST: begin
        err_d      = err_v;
        last_err_d = err_v;
        lost_d     = 1'b0;
        hold_cnt_d = hold_smp_q;
        state_d    = ST_EMIT;
        // The sign bit tells a positive error from a negative one.
        if (!err_v[EW-1] && err_v != '0 && err_v > peak_q) begin
          peak_d = err_v;
        end else if (err_v[EW-1] && err_v < peak_q) begin
          peak_d = err_v;
        end else if (err_v == '0 && peak_q != '0) begin
          // Centered: decay the peak by 4/5 on the shared divider.
          div_start = 1'b1;
          div_steps = CW'(DVW);
          div_rem   = '0;
          div_dvd   = {peak_mag, {DECAY_SHIFT{1'b0}}};
          div_den   = TW'(DECAY_DEN);
          neg_d     = peak_q[EW-1];
          state_d   = ST_DECAY;
        end
      end
      ST_DECAY: begin
        if (div_stat.done) begin
          peak_d  = neg_q ? -quo_s : quo_s;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Place the result once the output register is free.
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d = 1'b1;
          mdata_d  = OTW'($unsigned(err_q));
          muser_d  = lost_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state and registers with a defined reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      lthr_q     <= THR_RST;
      cthr_q     <= THR_RST;
      rthr_q     <= THR_RST;
      db_q       <= DB_RST;
      hold_smp_q <= HOLD_RST;
      peak_q     <= '0;
      last_err_q <= '0;
      hold_cnt_q <= '0;
      lost_q     <= 1'b0;
      mvalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      lthr_q     <= lthr_d;
      cthr_q     <= cthr_d;
      rthr_q     <= rthr_d;
      db_q       <= db_d;
      hold_smp_q <= hold_smp_d;
      peak_q     <= peak_d;
      last_err_q <= last_err_d;
      hold_cnt_q <= hold_cnt_d;
      lost_q     <= lost_d;
      mvalid_q   <= mvalid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    lsmp_q  <= lsmp_d;
    csmp_q  <= csmp_d;
    rsmp_q  <= rsmp_d;
    neg_q   <= neg_d;
    err_q   <= err_d;
    mdata_q <= mdata_d;
    muser_q <= muser_d;
  end

  // Shared divider for the error and the peak decay.
  lpet_div #(
    .ADC_BITS  (ADC_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .steps_i (div_steps),
    .rem_i   (div_rem),
    .dvd_i   (div_dvd),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .stat_o  (div_stat)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;
  assign m_axis_tuser  = muser_q;

  // The divider is never running while the block waits for an item.
  `LPET_ASSERT_NOW(a_idle_div_quiet, clk_i, rst_ni, state_q == ST_IDLE, !div_stat.busy)
  // A waiting result is never overwritten.
  `LPET_ASSERT_NEXT(a_emit_holds, clk_i, rst_ni,
                    state_q == ST_EMIT && mvalid_q && !m_axis_tready, state_q == ST_EMIT)
  // The lost flag is only raised once the hold count has run out.
  `LPET_ASSERT_NOW(a_lost_after_hold, clk_i, rst_ni, lost_q, hold_cnt_q == '0)
  // The peak direction stays within the error range.
  `LPET_ASSERT_NOW(a_peak_range, clk_i, rst_ni, 1'b1,
                   peak_q <= $signed(EW'(1) << (FRAC_BITS + 1)) &&
                   peak_q >= -$signed(EW'(1) << (FRAC_BITS + 1)))

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// Line position error tracker testbench
// Streams sets of left, center and right samples into the tracker and checks
// every error and lost flag against a predictor that runs alongside, over
// several register settings, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;
  import lpet_pkg::*;

  localparam int ADC    = ADC_BITS_DEF;
  localparam int FRAC   = FRAC_BITS_DEF;
  localparam int ERR_W  = FRAC + 3;
  localparam int IN_W   = ((3 * ADC + 7) / 8) * 8;
  localparam int OUT_W  = ((ERR_W + 7) / 8) * 8;
  localparam int ADC_MAX = (1 << ADC) - 1;
  localparam int CYCLE_LIMIT = 500000;

  // Expected error and lost flag for one item.
  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic                    lost;
  } steer_res_t;

  // Output stall patterns of the receiver.
  typedef enum int {RX_FREE, RX_RANDOM, RX_SPARSE} rx_mode_e;

  // Tracks the steering state and holds the results still due from the block.
  class steer_checker;
    int thr_l, thr_c, thr_r, dead_band, hold_set;
    int peak, last_err, hold_cnt;
    bit lost;
    int errors;
    steer_res_t due_q[$];

    function new();
      thr_l = THR_RST;
      thr_c = THR_RST;
      thr_r = THR_RST;
      dead_band = DB_RST;
      hold_set = HOLD_RST;
      peak = 0;
      last_err = 0;
      hold_cnt = 0;
      lost = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_LEFT_THR:   thr_l = val & ((1 << THR_W) - 1);
        REG_CENTER_THR: thr_c = val & ((1 << THR_W) - 1);
        REG_RIGHT_THR:  thr_r = val & ((1 << THR_W) - 1);
        REG_DEAD_BAND:  dead_band = val & ((1 << DB_W) - 1);
        REG_HOLD:       hold_set = val & ((1 << HOLD_W) - 1);
        default: ;
      endcase
    endfunction

    function int on_level(int s, int t);
      return (s < t) ? t - s : 0;
    endfunction

    // Works out the result of one accepted set of samples.
    function void note_samples(logic [ADC-1:0] l, logic [ADC-1:0] c, logic [ADC-1:0] r);
      int lon, con, ron, tot, num, mag, e, m;
      steer_res_t exp_r;
      lon = on_level(l, thr_l);
      con = on_level(c, thr_c);
      ron = on_level(r, thr_r);
      tot = lon + con + ron;
      if (tot > 0) begin
        num = (ron - lon) * 2 * (1 << FRAC);
        mag = (num < 0) ? -num : num;
        e = (num < 0) ? -(mag / tot) : mag / tot;
        if (e > -dead_band && e < dead_band) e = 0;
        if (e > 0 && e > peak) peak = e;
        else if (e < 0 && e < peak) peak = e;
        // A centered error lets the search direction decay by 4/5.
        if (e == 0) begin
          m = (peak < 0) ? -peak : peak;
          m = (m * 4) / 5;
          peak = (peak < 0) ? -m : m;
        end
        lost = 0;
        hold_cnt = hold_set;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
        lost = 0;
        e = last_err;
      end else begin
        e = peak;
        lost = 1;
      end
      last_err = e;
      exp_r.err = ERR_W'(e);
      exp_r.lost = lost;
      due_q.push_back(exp_r);
    endfunction

    function void check_result(logic [OUT_W-1:0] data, logic flag);
      steer_res_t exp_r;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected result: error %0d lost %0b", $time,
                 $signed(data[ERR_W-1:0]), flag);
        errors++;
        return;
      end
      exp_r = due_q.pop_front();
      if (data[ERR_W-1:0] !== exp_r.err) begin
        $display("%0t: line_error mismatch: expected %0d, actual %0d", $time,
                 exp_r.err, $signed(data[ERR_W-1:0]));
        errors++;
      end
      if (flag !== exp_r.lost) begin
        $display("%0t: lost_flag mismatch: expected %0b, actual %0b", $time,
                 exp_r.lost, flag);
        errors++;
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // left_sample, center_sample, right_sample, zero fill.
  logic [IN_W-1:0]       s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // line_error, zero fill.
  logic [OUT_W-1:0]      m_axis_tdata;
  // lost_flag.
  logic                  m_axis_tuser;

  steer_checker sb;
  int       burst_left = 0;
  int       stall_left = 0;
  rx_mode_e stall_mode = RX_FREE;
  int       cycles = 0;

  line_position_error_tracker DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run guard.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: checks each accepted result and stalls on its own pattern.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
    if (stall_left == 0) begin
      stall_mode <= rx_mode_e'($urandom_range(0, 2));
      stall_left <= $urandom_range(20, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      RX_FREE:   m_axis_tready <= 1'b1;
      RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default:   m_axis_tready <= (stall_left[3:0] == 4'd0);
    endcase
  end

  // Sample value for a sensor that sees the line or not; near keeps it just
  // below the threshold so that totals stay small.
  function automatic logic [ADC-1:0] sensor_value(bit on, int thr, bit near);
    if (!on) return $urandom_range(thr, ADC_MAX);
    if (thr == 0) return $urandom_range(0, ADC_MAX);
    if (near) return thr - $urandom_range(1, (thr < 24) ? thr : 24);
    return $urandom_range(0, thr - 1);
  endfunction

  // Sends one item, inserting a random gap between bursts.
  task automatic send_sample(logic [ADC-1:0] l, logic [ADC-1:0] c, logic [ADC-1:0] r);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_W'({r, c, l});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_samples(l, c, r);
  endtask

  // Holds the sender off until every result has come back.
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // Writes all registers, plus one unused index that must change nothing.
  task automatic set_config(int l, int c, int r, int db, int hold);
    cfg_write($urandom_range(REG_HOLD + 1, (1 << CFG_IDX_W) - 1),
              $urandom_range(0, (1 << CFG_DATA_W) - 1));
    cfg_write(REG_LEFT_THR, l);
    cfg_write(REG_CENTER_THR, c);
    cfg_write(REG_RIGHT_THR, r);
    cfg_write(REG_DEAD_BAND, db);
    cfg_write(REG_HOLD, hold);
    cfg_we_i <= 1'b0;
  endtask

  // Random traffic: mostly runs with the line in sight and runs with it
  // lost, some near the thresholds, and a little pure noise.
  task automatic random_items(int budget);
    int done_n, kind, run, k;
    bit [2:0] seen;
    bit near;
    done_n = 0;
    while (done_n < budget) begin
      kind = $urandom_range(0, 9);
      if (kind <= 7 && kind >= 6) run = $urandom_range(1, sb.hold_set + 3);
      else if (kind == 8) run = $urandom_range(1, 4);
      else run = $urandom_range(1, 12);
      // The last run stops at the budget.
      if (run > budget - done_n) run = budget - done_n;
      for (k = 0; k < run; k++) begin
        near = (kind == 9);
        if (kind == 6 || kind == 7) seen = 3'b000;
        else seen = $urandom_range(1, 7);
        if (kind == 8)
          send_sample($urandom_range(0, ADC_MAX), $urandom_range(0, ADC_MAX),
                      $urandom_range(0, ADC_MAX));
        else
          send_sample(sensor_value(seen[0], sb.thr_l, near),
                      sensor_value(seen[1], sb.thr_c, near),
                      sensor_value(seen[2], sb.thr_r, near));
      end
      done_n += run;
    end
  endtask

  initial begin
    int p;
    sb = new();
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_wdata_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items at the reset settings.
    send_sample(12'd4095, 12'd4095, 12'd4095);  // lost straight after reset
    send_sample(12'd0, 12'd0, 12'd0);           // all on line, centered
    send_sample(12'd0, 12'd4095, 12'd4095);     // full left
    send_sample(12'd4095, 12'd4095, 12'd0);     // full right
    send_sample(12'd4095, 12'd0, 12'd4095);     // centered, peak decays
    send_sample(12'd2047, 12'd2046, 12'd4095);  // negative quotient truncation
    send_sample(12'd4095, 12'd2030, 12'd2047);  // error equal to the dead band
    send_sample(12'd4095, 12'd2029, 12'd2047);  // error just inside the dead band
    // Line vanishes: held error for the hold count, then the peak and lost.
    repeat (7) send_sample(12'd4095, 12'd4095, 12'd4095);
    send_sample(12'd2048, 12'd2048, 12'd2048);  // samples at the thresholds
    send_sample(12'd2047, 12'd4095, 12'd4095);
    send_sample(12'd4095, 12'd4095, 12'd2047);
    send_sample(12'd0, 12'd0, 12'd4095);
    send_sample(12'd4095, 12'd0, 12'd0);
    send_sample(12'hAAA, 12'h555, 12'h123);
    wait_drain();

    // Register settings, the extremes first.
    for (p = 1; p <= 9; p++) begin
      case (p)
        1: set_config(4095, 4095, 4095, 0, 0);
        2: set_config(0, 0, 0, 512, 12'hFFF);
        3: set_config($urandom_range(0, ADC_MAX), $urandom_range(0, ADC_MAX),
                      $urandom_range(0, ADC_MAX), $urandom_range(0, 64), 255);
        4: set_config($urandom_range(0, ADC_MAX), $urandom_range(0, ADC_MAX),
                      $urandom_range(0, ADC_MAX), 12'hFFF, 3);
        default:
          set_config($urandom_range(0, ADC_MAX), $urandom_range(0, ADC_MAX),
                     $urandom_range(0, ADC_MAX),
                     $urandom_range(0, 512) | ($urandom_range(0, 3) << DB_W),
                     $urandom_range(0, 8) | ($urandom_range(0, 15) << HOLD_W));
      endcase
      case (p)
        2: random_items(15);
        3: random_items(280);
        4: random_items(50);
        default: random_items(60);
      endcase
      wait_drain();
    end

    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+design
design/lpet_pkg.sv
design/lpet_div.sv
design/line_position_error_tracker.sv
test/tb.sv
